### rtl/lkvc_pkg.sv
// ----------------------------------------------------------------------------
// lkvc_pkg
// Shared types and constants of the LRU key/value cache.
// ----------------------------------------------------------------------------
package lkvc_pkg;

    localparam int CAPACITY_DEF  = 64;
    localparam int KEY_W         = 64;
    localparam int VALUE_W       = 64;
    localparam int MAX_ENTRIES_W = 7;

    localparam logic [MAX_ENTRIES_W-1:0] MAX_ENTRIES_RST = 7'd64;

    // request opcodes
    localparam logic FUNC_LOOKUP = 1'b0;
    localparam logic FUNC_INSERT = 1'b1;

    typedef struct packed {
        logic               func;
        logic [KEY_W-1:0]   key;
        logic [VALUE_W-1:0] value;
    } req_t;

    typedef struct packed {
        logic               hit;
        logic [VALUE_W-1:0] found_value;
        logic               evicted;
        logic [KEY_W-1:0]   evicted_key;
        logic [VALUE_W-1:0] evicted_value;
    } rsp_t;

endpackage

### rtl/lkvc_core.sv
// ----------------------------------------------------------------------------
// lkvc_core
// Entry storage, parallel key compare, recency ranks and the replacement
// logic. Computes the response for the request in the input register and
// commits the new state on the same edge the response is registered.
// ----------------------------------------------------------------------------
module lkvc_core #(
    parameter int CAPACITY = lkvc_pkg::CAPACITY_DEF
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               fire,
    input  lkvc_pkg::req_t                     req,
    input  logic [lkvc_pkg::MAX_ENTRIES_W-1:0] max_entries,
    output lkvc_pkg::rsp_t                     rsp
);
    import lkvc_pkg::*;

    localparam int RankW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int OccW  = $clog2(CAPACITY + 1);
    localparam int LimW  = (OccW > MAX_ENTRIES_W) ? OccW : MAX_ENTRIES_W;

    logic [KEY_W-1:0]   key_reg   [CAPACITY];
    logic [VALUE_W-1:0] value_reg [CAPACITY];
    logic [RankW-1:0]   rank_reg  [CAPACITY];
    logic [CAPACITY-1:0] valid_reg;
    logic [OccW-1:0]    occ_reg;
    logic [OccW-1:0]    occ_next;

    logic [CAPACITY-1:0] match;
    logic [CAPACITY-1:0] evict_sel;
    logic [CAPACITY-1:0] free_slots;
    logic [CAPACITY-1:0] alloc_sel;
    logic                hit_any;
    logic                is_insert;
    logic                evict_do;
    logic [RankW-1:0]    rank_hit;
    logic [VALUE_W-1:0]  hit_value;
    logic [KEY_W-1:0]    ev_key;
    logic [VALUE_W-1:0]  ev_value;
    logic [LimW-1:0]     lim;
    logic [LimW-1:0]     occ_ext;
    logic [OccW-1:0]     occ_m1;
    logic [OccW-1:0]     occ_m2;
    logic [RankW-1:0]    target_rank;

    assign is_insert = (req.func == FUNC_INSERT);

    // parallel compare against every valid entry
    always_comb begin
        for (int i = 0; i < CAPACITY; i++) begin
            match[i] = valid_reg[i] && (key_reg[i] == req.key);
        end
    end

    assign hit_any = |match;

    // keys are unique among valid entries, so at most one match
    always_comb begin
        rank_hit  = '0;
        hit_value = '0;
        for (int i = 0; i < CAPACITY; i++) begin
            if (match[i]) begin
                rank_hit  = rank_hit | rank_reg[i];
                hit_value = hit_value | value_reg[i];
            end
        end
    end

    // effective limit: zero acts as one, saturates at capacity
    always_comb begin
        lim = LimW'(max_entries);
        if (max_entries == '0) begin
            lim = LimW'(1);
        end else if (lim > LimW'(CAPACITY)) begin
            lim = LimW'(CAPACITY);
        end
    end

    assign occ_ext = LimW'(occ_reg);
    assign occ_m1  = occ_reg - OccW'(1);
    assign occ_m2  = occ_reg - OccW'(2);

    // an update in place evicts only above the limit, a new key at the limit
    assign evict_do = is_insert && (hit_any ? (occ_ext > lim) : (occ_ext >= lim));

    // on an update in place the touched entry leaves the tail; if it was the
    // tail, the next older entry becomes least recent
    assign target_rank = (hit_any && (rank_hit == occ_m1[RankW-1:0])) ?
                         occ_m2[RankW-1:0] : occ_m1[RankW-1:0];

    always_comb begin
        for (int i = 0; i < CAPACITY; i++) begin
            evict_sel[i] = evict_do && valid_reg[i] && !match[i] &&
                           (rank_reg[i] == target_rank);
        end
    end

    always_comb begin
        ev_key   = '0;
        ev_value = '0;
        for (int i = 0; i < CAPACITY; i++) begin
            if (evict_sel[i]) begin
                ev_key   = ev_key | key_reg[i];
                ev_value = ev_value | value_reg[i];
            end
        end
    end

    // lowest free slot after the eviction
    assign free_slots = ~valid_reg | evict_sel;
    assign alloc_sel  = (is_insert && !hit_any) ?
                        (free_slots & (~free_slots + {{(CAPACITY-1){1'b0}}, 1'b1})) : '0;

    always_comb begin
        occ_next = occ_reg;
        if (evict_do) begin
            occ_next = occ_reg - OccW'(1);
        end
        if (|alloc_sel) begin
            occ_next = occ_next + OccW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
            occ_reg   <= '0;
        end else if (fire) begin
            valid_reg <= (valid_reg & ~evict_sel) | alloc_sel;
            occ_reg   <= occ_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (fire) begin
            for (int i = 0; i < CAPACITY; i++) begin
                if (hit_any) begin
                    if (match[i]) begin
                        rank_reg[i] <= '0;
                        if (is_insert) begin
                            value_reg[i] <= req.value;
                        end
                    end else if (valid_reg[i] && (rank_reg[i] < rank_hit)) begin
                        rank_reg[i] <= rank_reg[i] + RankW'(1);
                    end
                end else if (alloc_sel[i]) begin
                    key_reg[i]   <= req.key;
                    value_reg[i] <= req.value;
                    rank_reg[i]  <= '0;
                end else if (is_insert && valid_reg[i] && !evict_sel[i]) begin
                    rank_reg[i] <= rank_reg[i] + RankW'(1);
                end
            end
        end
    end

    always_comb begin
        rsp.hit           = hit_any;
        rsp.found_value   = (!is_insert && hit_any) ? hit_value : '0;
        rsp.evicted       = |evict_sel;
        rsp.evicted_key   = ev_key;
        rsp.evicted_value = ev_value;
    end

endmodule

### rtl/lru_key_value_cache.sv
// ----------------------------------------------------------------------------
// lru_key_value_cache
// Fully associative key/value cache with least-recently-used replacement.
// ----------------------------------------------------------------------------
// The cache takes one request per clock while the result side is not
// stalled and answers every request with exactly one response. The
// request sits in an input register, where the parallel key compare over
// all CAPACITY entries and the rank update run, and the response is
// captured in an output register while the entry state is updated on the
// same edge; that one compare-and-update pass sets the rate of one request
// per cycle. The store is empty after reset with no clearing pass.
// max_entries is written through cfg_wr_en and cfg_wr_data; the user must
// write it only while no request is in flight, which the block does not
// enforce. Zero acts as one and values above CAPACITY act as CAPACITY.
module lru_key_value_cache #(
    parameter int CAPACITY = lkvc_pkg::CAPACITY_DEF
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  lkvc_pkg::req_t                     s_data,
    output logic                               m_valid,
    input  logic                               m_ready,
    output lkvc_pkg::rsp_t                     m_data,
    input  logic                               cfg_wr_en,
    input  logic [lkvc_pkg::MAX_ENTRIES_W-1:0] cfg_wr_data
);
    import lkvc_pkg::*;

    logic                     in_valid_reg;
    req_t                     in_data_reg;
    logic                     out_valid_reg;
    rsp_t                     out_data_reg;
    logic [MAX_ENTRIES_W-1:0] max_entries_reg;
    logic                     advance;
    logic                     fire;
    rsp_t                     rsp;

    // output register free or draining this cycle
    assign advance = !out_valid_reg || m_ready;
    assign fire    = in_valid_reg && advance;
    assign s_ready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg    <= 1'b0;
            out_valid_reg   <= 1'b0;
            max_entries_reg <= MAX_ENTRIES_RST;
        end else begin
            if (s_ready) begin
                in_valid_reg <= s_valid;
            end
            if (advance) begin
                out_valid_reg <= in_valid_reg;
            end
            if (cfg_wr_en) begin
                max_entries_reg <= cfg_wr_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_data_reg <= s_data;
        end
        if (fire) begin
            out_data_reg <= rsp;
        end
    end

    lkvc_core #(
        .CAPACITY (CAPACITY)
    ) u_core (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .fire        (fire),
        .req         (in_data_reg),
        .max_entries (max_entries_reg),
        .rsp         (rsp)
    );

    assign m_valid = out_valid_reg;
    assign m_data  = out_data_reg;

endmodule
